// ----- design/ort_pkg.sv -----
// ----------------------------------------------------------------------------
// ort_pkg
// types and constants shared by the outstanding request tracker
// ----------------------------------------------------------------------------
`default_nettype none

package ort_pkg;

  localparam int unsigned ORT_ENTRIES     = 16;
  localparam int unsigned ORT_MAX_RESULTS = 16;
  localparam int unsigned ORT_ACTIVE_W    = 5;
  localparam logic [ORT_ACTIVE_W-1:0] ORT_ACTIVE_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_CONT    = 2'd1,
    OP_FINAL   = 2'd2,
    OP_TICK    = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_REQ_RESULT  = 2'd0,
    KIND_RESP_RESULT = 2'd1,
    KIND_RETRANSMIT  = 2'd2,
    KIND_TIMEOUT     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REQ_SCAN,
    ST_RESP_RD,
    ST_RESP_CHK,
    ST_TICK_RD,
    ST_TICK_EVAL
  } state_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] index_or_tag;
    logic [15:0] timeout_ticks;
    logic [7:0]  try_count;
    logic [31:0] session_key;
    logic [31:0] user_key;
    logic [31:0] terminal_key;
    logic [31:0] attribute_key;
    logic [31:0] message_type;
    logic [31:0] source_id;
    logic [31:0] destination_id;
    logic [31:0] response_type;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic        ok;
    logic [15:0] tag;
    logic [15:0] original_index;
    logic [31:0] out_message_type;
    logic [31:0] out_source;
    logic [31:0] out_destination;
    logic [31:0] out_session;
    logic [31:0] out_user;
    logic [31:0] out_terminal;
    logic [31:0] out_attribute;
    logic        last;
  } res_t;

  // one table slot as held in the slot memory
  typedef struct packed {
    logic [15:0] orig_index;
    logic [15:0] timeout;
    logic [15:0] countdown;
    logic [7:0]  tries_left;
    logic [31:0] session;
    logic [31:0] user;
    logic [31:0] terminal;
    logic [31:0] attribute;
    logic [31:0] message_type;
    logic [31:0] source;
    logic [31:0] destination;
    logic [31:0] response_type;
  } slot_t;

endpackage

`default_nettype wire

// ----- design/ort_if.sv -----
// ----------------------------------------------------------------------------
// ort_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
`default_nettype none

interface ort_req_if import ort_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ort_res_if import ort_pkg::*; ();
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/outstanding_request_tracker.sv -----
// ----------------------------------------------------------------------------
// outstanding_request_tracker
// table of outstanding requests with tag matching, timeout and retry
// ----------------------------------------------------------------------------
// a request probes for a free slot round-robin, one free-slot probe per cycle;
// a response does one slot read; a tick reads each valid slot of the active
// table, skips the empty ones and can stall while the output register is full.
// one input is worked at a time and a tick walks the whole active table; a new
// input is taken only in idle once the pending result has moved on. reset
// clears the valid flags at once, no clearing pass is needed.
`default_nettype none

module outstanding_request_tracker import ort_pkg::*; #(
  parameter int unsigned ENTRIES = ORT_ENTRIES
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [ORT_ACTIVE_W-1:0] cfg_wdata_i,
  ort_req_if.sink                      req_i,
  ort_res_if.source                    res_o
);

  localparam int unsigned SW = $clog2(ENTRIES);
  // count width, holds ENTRIES+1 for the round-robin wrap
  localparam int unsigned CW = $clog2(ENTRIES + 2);
  localparam int unsigned AW = (CW > ORT_ACTIVE_W) ? CW : ORT_ACTIVE_W;
  localparam int unsigned RW = $clog2(ORT_MAX_RESULTS + 1);

  state_e                    state_q, state_d;
  req_t                      in_q, in_d;
  logic [ENTRIES-1:0]        valid_q, valid_d;
  logic [CW-1:0]             last_given_q, last_given_d;
  logic [CW-1:0]             cand_q, cand_d;
  logic [CW-1:0]             iter_q, iter_d;
  logic [CW-1:0]             slot_q, slot_d;
  logic [RW-1:0]             nres_q, nres_d;
  res_t                      pend_q, pend_d;
  logic                      pend_valid_q, pend_valid_d;
  logic                      pend_done_q, pend_done_d;
  res_t                      out_q, out_d;
  logic                      out_valid_q, out_valid_d;
  logic [ORT_ACTIVE_W-1:0]   active_q;

  logic                      rd_en;
  logic [SW-1:0]             rd_addr;
  logic                      wr_en;
  logic [SW-1:0]             wr_addr;
  slot_t                     wr_data;
  slot_t                     rd_data;

  logic [CW-1:0]             n_used;
  logic [CW-1:0]             cand_nxt;
  logic                      out_free;
  logic                      tag_ok;

  ort_slot_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  // active count clamped to the table size
  always_comb begin
    if (AW'(active_q) > AW'(ENTRIES)) begin
      n_used = CW'(ENTRIES);
    end else begin
      n_used = CW'(active_q);
    end
  end

  // next round-robin candidate, 1-based
  always_comb begin
    cand_nxt = cand_q + 1'b1;
    if (cand_nxt > n_used) begin
      cand_nxt = CW'(1);
    end
  end

  // response tag points at a live slot inside the active range
  assign tag_ok = (in_q.index_or_tag != 16'd0) &&
                  (in_q.index_or_tag <= 16'(n_used)) &&
                  valid_q[SW'(in_q.index_or_tag - 16'd1)];

  assign out_free      = !out_valid_q || res_o.ready;
  assign req_i.ready   = (state_q == ST_IDLE) && !pend_valid_q;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  always_comb begin
    state_d      = state_q;
    in_d         = in_q;
    valid_d      = valid_q;
    last_given_d = last_given_q;
    cand_d       = cand_q;
    iter_d       = iter_q;
    slot_d       = slot_q;
    nres_d       = nres_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    pend_done_d  = pend_done_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    rd_en        = 1'b0;
    rd_addr      = SW'(slot_q);
    wr_en        = 1'b0;
    wr_addr      = SW'(slot_q);
    wr_data      = rd_data;

    // output register drains, a finished pending result moves up as last
    if (pend_valid_q && pend_done_q && out_free) begin
      out_d        = pend_q;
      out_d.last   = 1'b1;
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
      pend_done_d  = 1'b0;
    end else if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid && req_i.ready) begin
          in_d   = req_i.payload;
          cand_d = last_given_q;
          iter_d = '0;
          slot_d = '0;
          nres_d = '0;
          case (req_i.payload.opcode)
            OP_REQUEST: state_d = ST_REQ_SCAN;
            OP_CONT, OP_FINAL: state_d = ST_RESP_RD;
            default: state_d = ST_TICK_RD;
          endcase
        end
      end

      ST_REQ_SCAN: begin
        pend_d                = '0;
        pend_d.kind           = KIND_REQ_RESULT;
        pend_d.original_index = in_q.index_or_tag;
        if (in_q.timeout_ticks == 16'd0 || in_q.try_count == 8'd0 ||
            n_used == '0) begin
          pend_valid_d = 1'b1;
          pend_done_d  = 1'b1;
          state_d      = ST_IDLE;
        end else if (!valid_q[SW'(cand_nxt - 1'b1)]) begin
          // free slot found, claim it
          wr_en                 = 1'b1;
          wr_addr               = SW'(cand_nxt - 1'b1);
          wr_data.orig_index    = in_q.index_or_tag;
          wr_data.timeout       = in_q.timeout_ticks;
          wr_data.countdown     = in_q.timeout_ticks;
          wr_data.tries_left    = in_q.try_count;
          wr_data.session       = in_q.session_key;
          wr_data.user          = in_q.user_key;
          wr_data.terminal      = in_q.terminal_key;
          wr_data.attribute     = in_q.attribute_key;
          wr_data.message_type  = in_q.message_type;
          wr_data.source        = in_q.source_id;
          wr_data.destination   = in_q.destination_id;
          wr_data.response_type = in_q.response_type;
          valid_d[SW'(cand_nxt - 1'b1)] = 1'b1;
          last_given_d = cand_nxt;
          pend_d.ok    = 1'b1;
          pend_d.tag   = 16'(cand_nxt);
          pend_valid_d = 1'b1;
          pend_done_d  = 1'b1;
          state_d      = ST_IDLE;
        end else if (iter_q + 1'b1 >= n_used) begin
          // table full
          pend_valid_d = 1'b1;
          pend_done_d  = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cand_d = cand_nxt;
          iter_d = iter_q + 1'b1;
        end
      end

      ST_RESP_RD: begin
        if (tag_ok) begin
          rd_en   = 1'b1;
          rd_addr = SW'(in_q.index_or_tag - 16'd1);
          state_d = ST_RESP_CHK;
        end else begin
          pend_d       = '0;
          pend_d.kind  = KIND_RESP_RESULT;
          pend_d.tag   = in_q.index_or_tag;
          pend_valid_d = 1'b1;
          pend_done_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      ST_RESP_CHK: begin
        pend_d       = '0;
        pend_d.kind  = KIND_RESP_RESULT;
        pend_d.tag   = in_q.index_or_tag;
        pend_valid_d = 1'b1;
        pend_done_d  = 1'b1;
        state_d      = ST_IDLE;
        if (rd_data.session == in_q.session_key && rd_data.user == in_q.user_key &&
            rd_data.terminal == in_q.terminal_key &&
            rd_data.attribute == in_q.attribute_key) begin
          pend_d.ok             = 1'b1;
          pend_d.original_index = rd_data.orig_index;
          pend_d.out_session    = rd_data.session;
          pend_d.out_user       = rd_data.user;
          pend_d.out_terminal   = rd_data.terminal;
          pend_d.out_attribute  = rd_data.attribute;
          if (in_q.opcode == OP_FINAL) begin
            valid_d[SW'(in_q.index_or_tag - 16'd1)] = 1'b0;
          end
        end
      end

      ST_TICK_RD: begin
        if (slot_q >= n_used) begin
          // walk done, whatever is pending is the last result
          if (pend_valid_q) begin
            pend_done_d = 1'b1;
          end
          state_d = ST_IDLE;
        end else if (!valid_q[SW'(slot_q)]) begin
          slot_d = slot_q + 1'b1;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_TICK_EVAL;
        end
      end

      ST_TICK_EVAL: begin
        if (rd_data.countdown > 16'd1) begin
          wr_en             = 1'b1;
          wr_data.countdown = rd_data.countdown - 16'd1;
          slot_d            = slot_q + 1'b1;
          state_d           = ST_TICK_RD;
        end else if (nres_q >= RW'(ORT_MAX_RESULTS)) begin
          // over budget, expire again next tick
          wr_en             = 1'b1;
          wr_data.countdown = 16'd0;
          slot_d            = slot_q + 1'b1;
          state_d           = ST_TICK_RD;
        end else if (!pend_valid_q || out_free) begin
          // a newer expiry means the pending one is not last
          if (pend_valid_q) begin
            out_d       = pend_q;
            out_d.last  = 1'b0;
            out_valid_d = 1'b1;
          end
          pend_d                = '0;
          pend_d.ok             = 1'b1;
          pend_d.tag            = 16'(slot_q + 1'b1);
          pend_d.original_index = rd_data.orig_index;
          pend_d.out_source     = rd_data.source;
          pend_d.out_session    = rd_data.session;
          pend_d.out_user       = rd_data.user;
          pend_d.out_terminal   = rd_data.terminal;
          pend_d.out_attribute  = rd_data.attribute;
          if (rd_data.tries_left != 8'd0) begin
            wr_en                   = 1'b1;
            wr_data.tries_left      = rd_data.tries_left - 8'd1;
            wr_data.countdown       = rd_data.timeout;
            pend_d.kind             = KIND_RETRANSMIT;
            pend_d.out_message_type = rd_data.message_type;
            pend_d.out_destination  = rd_data.destination;
          end else begin
            valid_d[SW'(slot_q)]    = 1'b0;
            pend_d.kind             = KIND_TIMEOUT;
            pend_d.out_message_type = rd_data.response_type;
            pend_d.out_destination  = rd_data.source;
          end
          pend_valid_d = 1'b1;
          pend_done_d  = 1'b0;
          nres_d       = nres_q + 1'b1;
          slot_d       = slot_q + 1'b1;
          state_d      = ST_TICK_RD;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      last_given_q <= CW'(1);
      pend_valid_q <= 1'b0;
      pend_done_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      active_q     <= ORT_ACTIVE_RESET;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      last_given_q <= last_given_d;
      pend_valid_q <= pend_valid_d;
      pend_done_q  <= pend_done_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    cand_q <= cand_d;
    iter_q <= iter_d;
    slot_q <= slot_d;
    nres_q <= nres_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

endmodule

`default_nettype wire

// ----- design/ort_slot_mem.sv -----
// ----------------------------------------------------------------------------
// ort_slot_mem
// slot storage, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ort_slot_mem import ort_pkg::*; #(
  parameter int unsigned ENTRIES = ORT_ENTRIES
) (
  input  wire logic                       clk_i,
  input  wire logic                       rd_en_i,
  input  wire logic [$clog2(ENTRIES)-1:0] rd_addr_i,
  input  wire logic                       wr_en_i,
  input  wire logic [$clog2(ENTRIES)-1:0] wr_addr_i,
  input  wire slot_t                      wr_data_i,
  output slot_t                           rd_data_o
);

  slot_t mem_q [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire
